// ===== hw/rtl/lmf_pkg.sv =====
// ----------------------------------------------------------------------------
// Learning MAC-to-IP forwarder package
// Widths, register indexes, action codes, outcome codes and the command and
// status bundles shared by the controller and the datapath.
// ----------------------------------------------------------------------------
package lmf_pkg;

   localparam int MAC_W       = 48;
   localparam int CODE_W      = 8;
   localparam int IP_W        = 32;
   localparam int ACTION_W    = 3;
   localparam int SLOT_W      = 4;
   localparam int CSR_INDEX_W = 8;
   localparam int CSR_DATA_W  = 48;

   // Message id registers: the first three are server-to-node ids, the rest
   // are node-to-server ids.
   localparam int NUM_IDS     = 7;
   localparam int NUM_TO_NODE = 3;

   localparam logic [CSR_INDEX_W-1:0] REG_OWN_MAC          = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_ID_SET_MAC       = 8'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_ID_SET_CONFIG    = 8'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_ID_SET_TIME      = 8'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_ID_GET_MAC       = 8'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_ID_GET_CONFIG    = 8'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_ID_GET_TIME      = 8'd6;
   localparam logic [CSR_INDEX_W-1:0] REG_ID_STATUS_UPDATE = 8'd7;

   localparam logic [ACTION_W-1:0] ACT_LOCAL     = 3'd0;
   localparam logic [ACTION_W-1:0] ACT_TO_NODE   = 3'd1;
   localparam logic [ACTION_W-1:0] ACT_DROP      = 3'd2;
   localparam logic [ACTION_W-1:0] ACT_TO_SERVER = 3'd3;
   localparam logic [ACTION_W-1:0] ACT_IGNORE    = 3'd4;

   typedef enum logic [2:0] {
      OUT_LOCAL      = 3'd0,
      OUT_HIT_NODE   = 3'd1,
      OUT_DROP       = 3'd2,
      OUT_HIT_SERVER = 3'd3,
      OUT_LEARN      = 3'd4,
      OUT_FULL       = 3'd5,
      OUT_IGNORE     = 3'd6
   } outcome_type;

   typedef struct packed {
      logic        load;
      logic        scan_step;
      logic        finish;
      outcome_type outcome;
   } lmf_cmd_type;

   typedef struct packed {
      logic is_local;
      logic to_node;
      logic to_server;
      logic hit;
      logic miss_done;
      logic full;
      logic out_free;
   } lmf_stat_type;

endpackage

// ===== hw/rtl/lmf_channels.sv =====
// ----------------------------------------------------------------------------
// Forwarder channel interfaces
// Valid/ready channels for message headers, forwarding decisions and
// register writes.
// ----------------------------------------------------------------------------
interface lmf_req_if;
   import lmf_pkg::*;

   logic              valid;
   logic              ready;
   logic [MAC_W-1:0]  header_mac;
   logic [CODE_W-1:0] message_code;
   logic [IP_W-1:0]   sender_ipv4;

   modport source (output valid, output header_mac, output message_code,
                   output sender_ipv4, input ready);
   modport sink   (input valid, input header_mac, input message_code,
                   input sender_ipv4, output ready);
endinterface

interface lmf_rsp_if;
   import lmf_pkg::*;

   logic                valid;
   logic                ready;
   logic [ACTION_W-1:0] action;
   logic [IP_W-1:0]     next_hop_ip;
   logic [SLOT_W-1:0]   entry_slot;
   logic                learned;
   logic                table_full;

   modport source (output valid, output action, output next_hop_ip,
                   output entry_slot, output learned, output table_full,
                   input ready);
   modport sink   (input valid, input action, input next_hop_ip,
                   input entry_slot, input learned, input table_full,
                   output ready);
endinterface

interface lmf_csr_if;
   import lmf_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/learning_mac_to_ip_forwarder_unit.sv =====
// ----------------------------------------------------------------------------
// Learning MAC-to-IP forwarder
// Decides per received message header whether it is consumed locally,
// forwarded to a node, dropped, forwarded to the server or ignored, and
// learns MAC-to-IP pairs from node-to-server messages.
//
//   Channel  Direction  Contents
//   req_ch   in         header_mac, message_code, sender_ipv4
//   rsp_ch   out        action, next_hop_ip, entry_slot, learned, table_full
//   csr_ch   in         index, data (register write, always ready)
//
// A local or ignored item goes from acceptance through classification to the
// result register; a searched item also passes through the search, which reads
// one table entry a cycle and stops at the first hit or once every filled entry
// has missed. The controller returns to idle before it accepts the next item.
// Reset empties the table by clearing its fill count; no clearing pass runs.
// A result waits in its register until taken; the next item is accepted
// meanwhile and stalls only at its own result load.
// ----------------------------------------------------------------------------
module learning_mac_to_ip_forwarder_unit #(
   parameter int TABLE_ENTRIES = 16
) (
   input  logic         clock,
   input  logic         reset,
   lmf_req_if.sink      req_ch,
   lmf_rsp_if.source    rsp_ch,
   lmf_csr_if.sink      csr_ch
);
   import lmf_pkg::*;

   lmf_cmd_type  cmd;
   lmf_stat_type stat;
   logic         req_ready;

   assign req_ch.ready = req_ready;
   assign csr_ch.ready = 1'b1;

   lmf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   lmf_dp #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_dp (
      .clock            (clock),
      .reset            (reset),
      .csr_valid        (csr_ch.valid),
      .csr_index        (csr_ch.index),
      .csr_data         (csr_ch.data),
      .req_header_mac   (req_ch.header_mac),
      .req_message_code (req_ch.message_code),
      .req_sender_ipv4  (req_ch.sender_ipv4),
      .rsp_valid        (rsp_ch.valid),
      .rsp_ready        (rsp_ch.ready),
      .rsp_action       (rsp_ch.action),
      .rsp_next_hop_ip  (rsp_ch.next_hop_ip),
      .rsp_entry_slot   (rsp_ch.entry_slot),
      .rsp_learned      (rsp_ch.learned),
      .rsp_table_full   (rsp_ch.table_full),
      .cmd              (cmd),
      .stat             (stat)
   );

endmodule

// ===== hw/rtl/lmf_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module lmf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== hw/rtl/lmf_ctrl.sv =====
// ----------------------------------------------------------------------------
// Forwarder controller
// Sequences one item through classification, table search, learning and
// the result register.
// ----------------------------------------------------------------------------
module lmf_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  lmf_pkg::lmf_stat_type stat,
   output lmf_pkg::lmf_cmd_type  cmd
);
   import lmf_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE     = 4'b0001,
      ST_CLASSIFY = 4'b0010,
      ST_SEARCH   = 4'b0100,
      ST_FINISH   = 4'b1000
   } state_type;

   state_type   state_ff, state_in;
   outcome_type outcome_ff, outcome_in;

   always_comb begin
      state_in      = state_ff;
      outcome_in    = outcome_ff;
      req_ready     = 1'b0;
      cmd.load      = 1'b0;
      cmd.scan_step = 1'b0;
      cmd.finish    = 1'b0;
      cmd.outcome   = outcome_ff;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_CLASSIFY;
            end
         end
         ST_CLASSIFY: begin
            if (stat.is_local) begin
               outcome_in = OUT_LOCAL;
               state_in   = ST_FINISH;
            end else if (stat.to_node || stat.to_server) begin
               state_in = ST_SEARCH;
            end else begin
               outcome_in = OUT_IGNORE;
               state_in   = ST_FINISH;
            end
         end
         ST_SEARCH: begin
            if (stat.hit) begin
               outcome_in = stat.to_node ? OUT_HIT_NODE : OUT_HIT_SERVER;
               state_in   = ST_FINISH;
            end else if (stat.miss_done) begin
               if (stat.to_node) begin
                  outcome_in = OUT_DROP;
               end else if (stat.full) begin
                  outcome_in = OUT_FULL;
               end else begin
                  outcome_in = OUT_LEARN;
               end
               state_in = ST_FINISH;
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         ST_FINISH: begin
            if (stat.out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         outcome_ff <= OUT_IGNORE;
      end else begin
         state_ff   <= state_in;
         outcome_ff <= outcome_in;
      end
   end

endmodule

// ===== hw/rtl/lmf_dp.sv =====
// ----------------------------------------------------------------------------
// Forwarder datapath
// Configuration registers, header capture, MAC-to-IP table with its search
// pointer and fill count, and the result register.
// ----------------------------------------------------------------------------
module lmf_dp #(
   parameter int TABLE_ENTRIES = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   input  logic [lmf_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [lmf_pkg::CSR_DATA_W-1:0]      csr_data,
   input  logic [lmf_pkg::MAC_W-1:0]           req_header_mac,
   input  logic [lmf_pkg::CODE_W-1:0]          req_message_code,
   input  logic [lmf_pkg::IP_W-1:0]            req_sender_ipv4,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [lmf_pkg::ACTION_W-1:0]        rsp_action,
   output logic [lmf_pkg::IP_W-1:0]            rsp_next_hop_ip,
   output logic [lmf_pkg::SLOT_W-1:0]          rsp_entry_slot,
   output logic                                rsp_learned,
   output logic                                rsp_table_full,
   input  lmf_pkg::lmf_cmd_type                cmd,
   output lmf_pkg::lmf_stat_type               stat
);
   import lmf_pkg::*;

   localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CW = $clog2(TABLE_ENTRIES + 1);

   logic [MAC_W-1:0]    own_mac_ff;
   logic [CODE_W-1:0]   id_ff [NUM_IDS];
   logic [MAC_W-1:0]    mac_ff;
   logic [CODE_W-1:0]   code_ff;
   logic [IP_W-1:0]     sender_ff;
   logic [CW-1:0]       count_ff, count_in;
   logic [CW-1:0]       scan_ff, scan_in;
   logic                cmp_valid_ff, cmp_valid_in;
   logic [AW-1:0]       cmp_idx_ff;
   logic [AW-1:0]       hit_idx_ff;
   logic [IP_W-1:0]     hit_ip_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [ACTION_W-1:0] action_ff, action_in;
   logic [IP_W-1:0]     hop_ff, hop_in;
   logic [SLOT_W-1:0]   slot_ff, slot_in;
   logic                learned_ff, learned_in;
   logic                full_ff, full_in;

   logic [MAC_W-1:0]    key_rdata;
   logic [IP_W-1:0]     ip_rdata;
   logic                issue;
   logic                learn_we;
   logic                to_node;
   logic                to_server;
   logic [AW+SLOT_W-1:0] hit_ext;
   logic [AW+SLOT_W-1:0] learn_ext;

   lmf_ram #(.WIDTH(MAC_W), .DEPTH(TABLE_ENTRIES), .AW(AW)) u_key_ram (
      .clock (clock),
      .we    (learn_we),
      .waddr (count_ff[AW-1:0]),
      .wdata (mac_ff),
      .raddr (scan_ff[AW-1:0]),
      .rdata (key_rdata)
   );

   lmf_ram #(.WIDTH(IP_W), .DEPTH(TABLE_ENTRIES), .AW(AW)) u_ip_ram (
      .clock (clock),
      .we    (learn_we),
      .waddr (count_ff[AW-1:0]),
      .wdata (sender_ff),
      .raddr (scan_ff[AW-1:0]),
      .rdata (ip_rdata)
   );

   always_comb begin
      to_node   = 1'b0;
      to_server = 1'b0;
      for (int i = 0; i < NUM_IDS; i++) begin
         if (code_ff == id_ff[i]) begin
            if (i < NUM_TO_NODE) begin
               to_node = 1'b1;
            end else begin
               to_server = 1'b1;
            end
         end
      end
   end

   assign issue    = scan_ff < count_ff;
   assign learn_we = cmd.finish && (cmd.outcome == OUT_LEARN);

   assign stat.is_local  = mac_ff == own_mac_ff;
   assign stat.to_node   = to_node;
   assign stat.to_server = to_server;
   assign stat.hit       = cmp_valid_ff && (key_rdata == mac_ff);
   assign stat.miss_done = !cmp_valid_ff && !issue;
   assign stat.full      = count_ff == CW'(TABLE_ENTRIES);
   assign stat.out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      scan_in      = scan_ff;
      cmp_valid_in = 1'b0;
      if (cmd.load) begin
         scan_in = '0;
      end else if (cmd.scan_step && issue) begin
         scan_in      = scan_ff + CW'(1);
         cmp_valid_in = 1'b1;
      end
   end

   always_comb begin
      hit_ext   = {{SLOT_W{1'b0}}, hit_idx_ff};
      learn_ext = {{SLOT_W{1'b0}}, count_ff[AW-1:0]};
      count_in  = count_ff;
      if (learn_we) begin
         count_in = count_ff + CW'(1);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      action_in    = action_ff;
      hop_in       = hop_ff;
      slot_in      = slot_ff;
      learned_in   = learned_ff;
      full_in      = full_ff;
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
         hop_in       = '0;
         slot_in      = '0;
         learned_in   = 1'b0;
         full_in      = 1'b0;
         case (cmd.outcome)
            OUT_LOCAL: begin
               action_in = ACT_LOCAL;
            end
            OUT_HIT_NODE: begin
               action_in = ACT_TO_NODE;
               hop_in    = hit_ip_ff;
               slot_in   = hit_ext[SLOT_W-1:0];
            end
            OUT_DROP: begin
               action_in = ACT_DROP;
            end
            OUT_HIT_SERVER: begin
               action_in = ACT_TO_SERVER;
               slot_in   = hit_ext[SLOT_W-1:0];
            end
            OUT_LEARN: begin
               action_in  = ACT_TO_SERVER;
               slot_in    = learn_ext[SLOT_W-1:0];
               learned_in = 1'b1;
            end
            OUT_FULL: begin
               action_in = ACT_TO_SERVER;
               full_in   = 1'b1;
            end
            default: begin
               action_in = ACT_IGNORE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         own_mac_ff   <= '0;
         for (int i = 0; i < NUM_IDS; i++) begin
            id_ff[i] <= '0;
         end
         count_ff     <= '0;
         scan_ff      <= '0;
         cmp_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            if (csr_index == REG_OWN_MAC) begin
               own_mac_ff <= csr_data[MAC_W-1:0];
            end
            for (int i = 0; i < NUM_IDS; i++) begin
               if (csr_index == REG_ID_SET_MAC + CSR_INDEX_W'(i)) begin
                  id_ff[i] <= csr_data[CODE_W-1:0];
               end
            end
         end
         count_ff     <= count_in;
         scan_ff      <= scan_in;
         cmp_valid_ff <= cmp_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mac_ff    <= req_header_mac;
         code_ff   <= req_message_code;
         sender_ff <= req_sender_ipv4;
      end
      cmp_idx_ff <= scan_ff[AW-1:0];
      if (stat.hit) begin
         hit_idx_ff <= cmp_idx_ff;
         hit_ip_ff  <= ip_rdata;
      end
      action_ff  <= action_in;
      hop_ff     <= hop_in;
      slot_ff    <= slot_in;
      learned_ff <= learned_in;
      full_ff    <= full_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_action      = action_ff;
   assign rsp_next_hop_ip = hop_ff;
   assign rsp_entry_slot  = slot_ff;
   assign rsp_learned     = learned_ff;
   assign rsp_table_full  = full_ff;

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Learning MAC-to-IP forwarder testbench
// Drives message headers through the forwarder under random sender bursts and
// receiver stalls. Each accepted header is run through a behavioural copy of
// the forwarding table, and every decision that comes back is checked against
// the oldest prediction. The register settings change between phases, once
// every outstanding decision has been taken.
// ----------------------------------------------------------------------------
module testbench;
   import lmf_pkg::*;

   localparam int TABLE_DEPTH    = 16;
   localparam int MISMATCH_SHOWN = 10;
   localparam int SETTLE_CYCLES  = 40;
   localparam int HOLD_CYCLES    = 400;
   localparam int HOLD_AT_FIRST  = 300;
   localparam int HOLD_AT_SECOND = 1200;
   localparam time RUN_LIMIT     = 5_000_000;

   localparam logic [CSR_INDEX_W-1:0] REG_BEYOND_FIRST =
      CSR_INDEX_W'(REG_ID_STATUS_UPDATE + 1);
   localparam logic [CSR_INDEX_W-1:0] REG_BEYOND_LAST  = '1;
   localparam logic [CODE_W-1:0]      UNUSED_CODE      = 8'h99;

   typedef struct packed {
      logic [MAC_W-1:0]  mac;
      logic [CODE_W-1:0] code;
      logic [IP_W-1:0]   ip;
   } header_type;

   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic [IP_W-1:0]     next_hop_ip;
      logic [SLOT_W-1:0]   entry_slot;
      logic                learned;
      logic                table_full;
   } decision_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   lmf_req_if req_ch ();
   lmf_rsp_if rsp_ch ();
   lmf_csr_if csr_ch ();

   learning_mac_to_ip_forwarder_unit #(
      .TABLE_ENTRIES(TABLE_DEPTH)
   ) DUT (
      .clock (clock),
      .reset (reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch),
      .csr_ch(csr_ch)
   );

   header_type       headers_waiting[$];
   decision_type     decisions_due[$];
   logic [MAC_W-1:0] seen_macs[$];

   logic [MAC_W-1:0]  own_mac_cfg;
   logic [CODE_W-1:0] id_code[NUM_IDS];
   logic [MAC_W-1:0]  mac_table[TABLE_DEPTH];
   logic [IP_W-1:0]   ip_table[TABLE_DEPTH];
   int                table_fill;

   header_type   next_header;
   decision_type got_decision;
   decision_type want_decision;
   int           mismatches;
   int           results_taken;
   int           burst_left;
   int           gap_left;
   int           hold_left;
   int           pattern_pos;
   logic [15:0]  ready_pattern;
   logic         hold_start;

   always #5 clock = ~clock;

   function automatic decision_type forward_decision(input header_type h);
      decision_type d;
      logic         to_node;
      logic         to_server;
      int           hit;
      d         = '0;
      d.action  = ACT_IGNORE;
      to_node   = 1'b0;
      to_server = 1'b0;
      hit       = -1;
      for (int i = 0; i < NUM_IDS; i++) begin
         if (h.code == id_code[i]) begin
            if (i < NUM_TO_NODE) to_node = 1'b1;
            else to_server = 1'b1;
         end
      end
      if (to_node || to_server) begin
         for (int i = table_fill - 1; i >= 0; i--) begin
            if (mac_table[i] == h.mac) hit = i;
         end
      end
      if (h.mac == own_mac_cfg) begin
         d.action = ACT_LOCAL;
      end else if (to_node) begin
         if (hit < 0) begin
            d.action = ACT_DROP;
         end else begin
            d.action      = ACT_TO_NODE;
            d.next_hop_ip = ip_table[hit];
            d.entry_slot  = hit[SLOT_W-1:0];
         end
      end else if (to_server) begin
         d.action = ACT_TO_SERVER;
         if (hit >= 0) begin
            d.entry_slot = hit[SLOT_W-1:0];
         end else if (table_fill < TABLE_DEPTH) begin
            mac_table[table_fill] = h.mac;
            ip_table[table_fill]  = h.ip;
            d.entry_slot          = table_fill[SLOT_W-1:0];
            d.learned             = 1'b1;
            table_fill++;
         end else begin
            d.table_full = 1'b1;
         end
      end
      return d;
   endfunction

   function automatic logic [MAC_W-1:0] random_mac();
      logic [63:0] w;
      w = {$urandom, $urandom};
      return w[MAC_W-1:0];
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         burst_left   <= 1;
         gap_left     <= 0;
      end else if (!(req_ch.valid && !req_ch.ready)) begin
         if (req_ch.valid) begin
            decisions_due.push_back(forward_decision(
               '{mac: req_ch.header_mac, code: req_ch.message_code, ip: req_ch.sender_ipv4}));
         end
         if (gap_left > 0) begin
            req_ch.valid <= 1'b0;
            gap_left     <= gap_left - 1;
         end else if (headers_waiting.size() > 0) begin
            next_header         = headers_waiting.pop_front();
            req_ch.valid        <= 1'b1;
            req_ch.header_mac   <= next_header.mac;
            req_ch.message_code <= next_header.code;
            req_ch.sender_ipv4  <= next_header.ip;
            if (burst_left > 1) begin
               burst_left <= burst_left - 1;
            end else begin
               burst_left <= $urandom_range(24, 1);
               gap_left   <= ($urandom_range(4) == 0) ? 0 : $urandom_range(10, 1);
            end
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready  <= 1'b0;
         hold_left     <= 0;
         pattern_pos   <= 0;
         ready_pattern <= 16'hFFFF;
         results_taken <= 0;
      end else begin
         hold_start = 1'b0;
         if (rsp_ch.valid && rsp_ch.ready) begin
            got_decision = '{action: rsp_ch.action, next_hop_ip: rsp_ch.next_hop_ip,
                             entry_slot: rsp_ch.entry_slot, learned: rsp_ch.learned,
                             table_full: rsp_ch.table_full};
            if (decisions_due.size() == 0) begin
               if (mismatches < MISMATCH_SHOWN)
                  $display("%0t: decision arrived with none outstanding: action %0d", $time,
                           got_decision.action);
               mismatches++;
            end else begin
               want_decision = decisions_due.pop_front();
               if (got_decision !== want_decision) begin
                  if (mismatches < MISMATCH_SHOWN)
                     $display("%0t: expected action %0d hop %h slot %0d learned %b full %b, got action %0d hop %h slot %0d learned %b full %b",
                              $time, want_decision.action, want_decision.next_hop_ip,
                              want_decision.entry_slot, want_decision.learned,
                              want_decision.table_full, got_decision.action,
                              got_decision.next_hop_ip, got_decision.entry_slot,
                              got_decision.learned, got_decision.table_full);
                  mismatches++;
               end
            end
            results_taken <= results_taken + 1;
            hold_start = (results_taken + 1 == HOLD_AT_FIRST) ||
                         (results_taken + 1 == HOLD_AT_SECOND);
         end
         if (hold_start) hold_left <= HOLD_CYCLES;
         else if (hold_left > 0) hold_left <= hold_left - 1;
         if (hold_start || hold_left > 0) rsp_ch.ready <= 1'b0;
         else rsp_ch.ready <= ready_pattern[pattern_pos % 16];
         if (pattern_pos == 127) begin
            pattern_pos   <= 0;
            ready_pattern <= ($urandom_range(3) == 0) ? 16'hFFFF :
                             (16'($urandom) | 16'h0001);
         end else begin
            pattern_pos <= pattern_pos + 1;
         end
      end
   end

   task automatic write_register(input logic [CSR_INDEX_W-1:0] index,
                                 input logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= index;
      csr_ch.data  <= data;
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
      if (index == REG_OWN_MAC) own_mac_cfg = data[MAC_W-1:0];
      else if (index <= REG_ID_STATUS_UPDATE) id_code[index - REG_ID_SET_MAC] = data[CODE_W-1:0];
   endtask

   task automatic load_settings(input logic [MAC_W-1:0] own,
                                input logic [NUM_IDS*CODE_W-1:0] ids);
      logic [CSR_DATA_W-1:0] word;
      write_register(REG_OWN_MAC, own);
      for (int i = 0; i < NUM_IDS; i++) begin
         word                = random_mac();
         word[CODE_W-1:0]    = ids[i*CODE_W +: CODE_W];
         write_register(CSR_INDEX_W'(REG_ID_SET_MAC + i), word);
      end
   endtask

   task automatic queue_header(input logic [MAC_W-1:0] mac, input logic [CODE_W-1:0] code,
                               input logic [IP_W-1:0] ip);
      headers_waiting.push_back('{mac: mac, code: code, ip: ip});
   endtask

   task automatic queue_random(input int count);
      header_type h;
      int         pick;
      logic       server_bound;
      for (int n = 0; n < count; n++) begin
         pick         = $urandom_range(99);
         server_bound = 1'b0;
         if (pick < 35) begin
            h.code = id_code[$urandom_range(NUM_TO_NODE - 1)];
         end else if (pick < 70) begin
            h.code       = id_code[$urandom_range(NUM_IDS - 1, NUM_TO_NODE)];
            server_bound = 1'b1;
         end else if (pick < 75) begin
            h.code = {CODE_W{pick[0]}};
         end else begin
            h.code = CODE_W'($urandom);
         end
         pick = $urandom_range(99);
         if (pick < 8) begin
            h.mac = own_mac_cfg;
         end else if (pick < 14) begin
            h.mac = '0;
            if (pick < 10) h.mac = '1;
            else if (pick >= 12) h.mac[$urandom_range(MAC_W - 1)] = 1'b1;
         end else if (seen_macs.size() > 0 && (pick < 60 || (server_bound && pick < 94))) begin
            h.mac = seen_macs[$urandom_range(seen_macs.size() - 1)];
         end else begin
            h.mac = random_mac();
            if (server_bound) seen_macs.push_back(h.mac);
         end
         pick = $urandom_range(9);
         h.ip = (pick == 0) ? '0 : (pick == 1) ? '1 : $urandom;
         headers_waiting.push_back(h);
      end
   endtask

   task automatic queue_learn_burst(input int count);
      logic [MAC_W-1:0] mac;
      for (int n = 0; n < count; n++) begin
         mac = random_mac();
         seen_macs.push_back(mac);
         queue_header(mac, id_code[$urandom_range(NUM_IDS - 1, NUM_TO_NODE)], $urandom);
      end
   endtask

   task automatic await_idle();
      while (headers_waiting.size() != 0 || req_ch.valid || decisions_due.size() != 0)
         @(negedge clock);
   endtask

   initial begin
      logic [63:0]               draw;
      logic [NUM_IDS*CODE_W-1:0] ids;
      req_ch.valid        = 1'b0;
      req_ch.header_mac   = '0;
      req_ch.message_code = '0;
      req_ch.sender_ipv4  = '0;
      rsp_ch.ready        = 1'b0;
      csr_ch.valid        = 1'b0;
      csr_ch.index        = '0;
      csr_ch.data         = '0;
      own_mac_cfg         = '0;
      table_fill          = 0;
      mismatches          = 0;
      foreach (id_code[i]) id_code[i] = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: own MAC and every id are zero, so code zero searches the table unless the MAC is zero too.
      queue_header('0, '0, 32'h0A00_0001);
      queue_header('1, '0, '1);
      queue_header('1, '1, '0);
      queue_header(48'h5A5A_5A5A_5A5A, 8'h7E, 32'h1234_5678);
      await_idle();

      load_settings(48'h0123_4567_89AB, {8'h23, 8'h22, 8'h21, 8'h20, 8'h12, 8'h11, 8'h10});
      write_register(REG_BEYOND_FIRST, '1);
      write_register(REG_BEYOND_LAST, random_mac());
      queue_header('1, id_code[3], '1);
      queue_header(48'h1, id_code[4], '0);
      queue_header('0, id_code[5], 32'hC0A8_0001);
      queue_header('1, id_code[6], '0);
      queue_header(own_mac_cfg, id_code[3], 32'hDEAD_BEEF);
      queue_header(own_mac_cfg, UNUSED_CODE, '1);
      queue_header('1, id_code[0], '0);
      queue_header(48'h1, id_code[1], '1);
      queue_header('0, id_code[2], '0);
      queue_header(48'hA5A5_A5A5_A5A5, id_code[0], '1);
      queue_header(48'h1, '1, '1);
      queue_header(48'h1, '0, '1);
      seen_macs.push_back('1);
      seen_macs.push_back(48'h1);
      seen_macs.push_back('0);
      await_idle();

      draw = {$urandom, $urandom};
      load_settings(random_mac(), draw[NUM_IDS*CODE_W-1:0]);
      queue_random(600);
      await_idle();

      // Overlapping codes: set-time equals get-MAC, set-MAC equals get-config.
      load_settings('1, {8'hFF, 8'h43, 8'h00, 8'h42, 8'h42, 8'h41, 8'h00});
      queue_random(500);
      await_idle();

      load_settings('0, '1);
      queue_random(150);
      await_idle();

      draw = {$urandom, $urandom};
      for (int i = 0; i < NUM_IDS; i++)
         ids[i*CODE_W +: CODE_W] = {(i >= NUM_TO_NODE), draw[i*CODE_W +: CODE_W-1]};
      load_settings(random_mac(), ids);
      queue_learn_burst(20);
      queue_random(430);
      await_idle();

      repeat (SETTLE_CYCLES) @(posedge clock);
      mismatches += decisions_due.size();
      if (mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   initial begin
      #(RUN_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

// ===== filelist.f =====
hw/rtl/lmf_pkg.sv
hw/rtl/lmf_channels.sv
hw/rtl/lmf_ram.sv
hw/rtl/lmf_ctrl.sv
hw/rtl/lmf_dp.sv
hw/rtl/learning_mac_to_ip_forwarder_unit.sv
tb/sv/testbench.sv
